FILE: hw/rtl/hspt_pkg.sv
package hspt_pkg;

  // Width of the debounce time register
  localparam int unsigned FILTER_TIME_WIDTH = 16;
  // Distance bits checked for fault recovery
  localparam int unsigned DIST_WIDTH = 8;
  // Reset value of the debounce time, in ms
  localparam logic [FILTER_TIME_WIDTH-1:0] FILTER_TIME_RESET = 16'd2;
  // Recovery needs a distance above this
  localparam logic [DIST_WIDTH-1:0] DIST_LIMIT = 8'd1;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_DIR_MAP     = 1'b0,
    CFG_FILTER_TIME = 1'b1
  } cfg_index_t;

  // Window state encoding
  typedef enum logic [1:0] {
    WS_SHUT   = 2'd0,
    WS_OPEN   = 2'd1,
    WS_PARTLY = 2'd2,
    WS_OTHER  = 2'd3
  } win_state_t;

  // Edge qualification from the debounce filter
  typedef struct packed {
    logic edge_low;  // hall pin low, edge is considered
    logic accept;    // edge passed the deadline check
  } filt_status_t;

endpackage

FILE: hw/rtl/hspt_filter.sv
module hspt_filter
  import hspt_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         fire,
  input  logic [TIME_WIDTH-1:0]        timestamp,
  input  logic                         hall_level,
  input  logic [FILTER_TIME_WIDTH-1:0] filter_time,
  output filt_status_t                 status
);

  logic [TIME_WIDTH-1:0] deadline_r;
  logic [TIME_WIDTH-1:0] deadline_nxt;

  // Strict unsigned compare against the stored deadline
  always_comb begin
    status.edge_low = ~hall_level;
    status.accept   = ~hall_level & (timestamp > deadline_r);
  end

  // Deadline renews on every low edge, accepted or not; wraps modulo time width
  assign deadline_nxt = timestamp + TIME_WIDTH'(filter_time);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadline_r <= '0;
    end else if (fire && status.edge_low) begin
      deadline_r <= deadline_nxt;
    end
  end

endmodule

FILE: hw/rtl/hspt_track.sv
module hspt_track
  import hspt_pkg::*;
#(
  parameter int unsigned POSITION_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             fire,
  input  filt_status_t                     status,
  input  logic                             direction_level,
  input  logic [1:0]                       window_state,
  input  logic                             fault_active,
  input  logic                             dir_map,
  output logic                             accepted,
  output logic                             moving_closed,
  output logic signed [POSITION_WIDTH-1:0] position,
  output logic [1:0]                       new_window_state,
  output logic                             battery_flag_clear,
  output logic                             fault_recovered
);

  logic [POSITION_WIDTH-1:0] step_count_r;
  logic [POSITION_WIDTH-1:0] step_count_nxt;
  logic [POSITION_WIDTH-1:0] fault_ref_r;
  logic [POSITION_WIDTH-1:0] fault_ref_nxt;
  logic [POSITION_WIDTH-1:0] diff_up;
  logic [POSITION_WIDTH-1:0] diff_dn;
  logic [DIST_WIDTH-1:0]     dist_lo;
  logic                      ref_empty;
  logic                      from_shut;
  logic                      manual;
  logic                      recover;

  assign accepted      = status.accept;
  assign moving_closed = status.accept & direction_level;

  // Up when opening, down when closing; wraps
  assign step_count_nxt = direction_level ? (step_count_r - 1'b1) : (step_count_r + 1'b1);
  assign position       = status.accept ? $signed(step_count_nxt) : $signed(step_count_r);

  // Manual move: direction equal to mapping leaves shut, otherwise leaves open
  assign from_shut = (direction_level == dir_map);
  assign manual    = status.accept &
                     (from_shut ? (window_state == WS_SHUT) : (window_state == WS_OPEN));
  assign new_window_state   = manual ? WS_PARTLY : window_state;
  assign battery_flag_clear = manual & from_shut;

  // Absolute distance from the fault reference, low bits only
  assign ref_empty = (fault_ref_r == '0);
  assign diff_up   = step_count_nxt - fault_ref_r;
  assign diff_dn   = fault_ref_r - step_count_nxt;
  assign dist_lo   = ($signed(step_count_nxt) > $signed(fault_ref_r)) ?
                     diff_up[DIST_WIDTH-1:0] : diff_dn[DIST_WIDTH-1:0];
  assign recover   = status.accept & fault_active & ~ref_empty & (dist_lo > DIST_LIMIT);
  assign fault_recovered = recover;

  // Reference: sample when empty, clear on recovery
  always_comb begin
    fault_ref_nxt = fault_ref_r;
    if (status.accept && fault_active) begin
      if (ref_empty) begin
        fault_ref_nxt = step_count_nxt;
      end else if (recover) begin
        fault_ref_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_count_r <= '0;
      fault_ref_r  <= '0;
    end else if (fire) begin
      if (status.accept) begin
        step_count_r <= step_count_nxt;
      end
      fault_ref_r <= fault_ref_nxt;
    end
  end

endmodule

FILE: hw/rtl/hall_step_position_tracker.sv
// Hall step position tracker: debounces falling hall edges against a deadline
// (timestamp plus filter time), counts accepted edges up or down into a
// wrapping signed position, flags manual moves out of an end position and
// reports recovery from a hall fault. One request is taken per clock cycle while the
// result register can drain; each result passes through an input register, then
// a result register, and the deadline and step counter update as a request moves
// between those registers. A held result stops the next request from entering
// the input register only once that register is also full.
module hall_step_position_tracker
  import hspt_pkg::*;
#(
  parameter int unsigned POSITION_WIDTH = 16,
  parameter int unsigned TIME_WIDTH     = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_we,
  input  logic [0:0]                       cfg_index,
  input  logic [FILTER_TIME_WIDTH-1:0]     cfg_wdata,
  // input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [TIME_WIDTH-1:0]            in_timestamp,
  input  logic                             in_hall_level,
  input  logic                             in_direction_level,
  input  logic [1:0]                       in_window_state,
  input  logic                             in_fault_active,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_accepted,
  output logic                             out_moving_closed,
  output logic signed [POSITION_WIDTH-1:0] out_position,
  output logic [1:0]                       out_new_window_state,
  output logic                             out_battery_flag_clear,
  output logic                             out_fault_recovered
);

  logic                             dir_map_r;
  logic [FILTER_TIME_WIDTH-1:0]     filter_time_r;

  logic                             s1_valid_r;
  logic [TIME_WIDTH-1:0]            s1_timestamp_r;
  logic                             s1_hall_r;
  logic                             s1_dir_r;
  logic [1:0]                       s1_wstate_r;
  logic                             s1_fault_r;

  logic                             out_valid_r;
  logic                             out_accepted_r;
  logic                             out_moving_r;
  logic signed [POSITION_WIDTH-1:0] out_position_r;
  logic [1:0]                       out_wstate_r;
  logic                             out_bat_clear_r;
  logic                             out_recovered_r;

  logic                             adv;
  logic                             in_fire;
  filt_status_t                     filt;

  logic                             t_accepted;
  logic                             t_moving;
  logic signed [POSITION_WIDTH-1:0] t_position;
  logic [1:0]                       t_wstate;
  logic                             t_bat_clear;
  logic                             t_recovered;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_map_r     <= 1'b0;
      filter_time_r <= FILTER_TIME_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_DIR_MAP:     dir_map_r     <= cfg_wdata[0];
        CFG_FILTER_TIME: filter_time_r <= cfg_wdata;
        default:         ;
      endcase
    end
  end

  // Flow control: stage 1 moves into the result register when it is empty or being read
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;
  assign in_fire  = in_valid && in_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_timestamp_r <= in_timestamp;
      s1_hall_r      <= in_hall_level;
      s1_dir_r       <= in_direction_level;
      s1_wstate_r    <= in_window_state;
      s1_fault_r     <= in_fault_active;
    end
  end

  hspt_filter #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_filter (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (adv),
    .timestamp   (s1_timestamp_r),
    .hall_level  (s1_hall_r),
    .filter_time (filter_time_r),
    .status      (filt)
  );

  hspt_track #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_track (
    .clk                (clk),
    .rst_n              (rst_n),
    .fire               (adv),
    .status             (filt),
    .direction_level    (s1_dir_r),
    .window_state       (s1_wstate_r),
    .fault_active       (s1_fault_r),
    .dir_map            (dir_map_r),
    .accepted           (t_accepted),
    .moving_closed      (t_moving),
    .position           (t_position),
    .new_window_state   (t_wstate),
    .battery_flag_clear (t_bat_clear),
    .fault_recovered    (t_recovered)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_accepted_r  <= t_accepted;
      out_moving_r    <= t_moving;
      out_position_r  <= t_position;
      out_wstate_r    <= t_wstate;
      out_bat_clear_r <= t_bat_clear;
      out_recovered_r <= t_recovered;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_accepted           = out_accepted_r;
  assign out_moving_closed      = out_moving_r;
  assign out_position           = out_position_r;
  assign out_new_window_state   = out_wstate_r;
  assign out_battery_flag_clear = out_bat_clear_r;
  assign out_fault_recovered    = out_recovered_r;

  // A battery flag clear only comes with an accepted manual move
  a_bat_clear_manual: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_bat_clear_r |-> out_accepted_r && out_wstate_r == WS_PARTLY)
    else $error("battery flag clear without manual move");

  // Recovery is only reported on an accepted edge
  a_recover_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_recovered_r |-> out_accepted_r)
    else $error("fault recovery on a rejected edge");

  // A request held in stage 1 is not dropped while the result side stalls
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r && $stable(s1_timestamp_r))
    else $error("stage 1 request lost during stall");

  // Position only moves on an accepted edge
  a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !filt.accept |-> t_position == $signed(u_track.step_count_r))
    else $error("position changed on a rejected edge");

endmodule

FILE: test/hspt_step_checker.sv
module hspt_step_checker
  import hspt_pkg::*;
#(
  parameter int unsigned POSITION_WIDTH = 16,
  parameter int unsigned TIME_WIDTH     = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [0:0]                       cfg_index,
  input  logic [FILTER_TIME_WIDTH-1:0]     cfg_wdata,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [TIME_WIDTH-1:0]            in_timestamp,
  input  logic                             in_hall_level,
  input  logic                             in_direction_level,
  input  logic [1:0]                       in_window_state,
  input  logic                             in_fault_active,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic                             out_accepted,
  input  logic                             out_moving_closed,
  input  logic signed [POSITION_WIDTH-1:0] out_position,
  input  logic [1:0]                       out_new_window_state,
  input  logic                             out_battery_flag_clear,
  input  logic                             out_fault_recovered,
  output int                               mismatches,
  output int                               in_flight
);

  typedef struct packed {
    logic                             accepted;
    logic                             moving_closed;
    logic signed [POSITION_WIDTH-1:0] position;
    win_state_t                       new_window_state;
    logic                             battery_flag_clear;
    logic                             fault_recovered;
  } step_result_t;

  // Shadow copy of the tracker registers and state
  logic                         dir_swapped;
  logic [FILTER_TIME_WIDTH-1:0] filter_ms;
  logic [TIME_WIDTH-1:0]        deadline;
  logic [POSITION_WIDTH-1:0]    step_cnt;
  logic [POSITION_WIDTH-1:0]    fault_ref;

  step_result_t expected_steps[$];

  // Debounce one edge, step the counter and work out the result it gives
  function automatic step_result_t track_edge(input logic [TIME_WIDTH-1:0] ts,
                                              input logic hall, input logic closing,
                                              input win_state_t ws, input logic fault);
    step_result_t             r;
    longint                   dist_full;
    logic [DIST_WIDTH-1:0]    dist_lo;
    r = '0;
    r.new_window_state = ws;
    if (!hall) begin
      if (ts > deadline) begin
        r.accepted = 1'b1;
        r.moving_closed = closing;
        if (!closing) begin
          step_cnt = step_cnt + 1'b1;
          if (!dir_swapped && ws == WS_SHUT) begin
            r.new_window_state = WS_PARTLY;
            r.battery_flag_clear = 1'b1;
          end else if (dir_swapped && ws == WS_OPEN) begin
            r.new_window_state = WS_PARTLY;
          end
        end else begin
          step_cnt = step_cnt - 1'b1;
          if (!dir_swapped && ws == WS_OPEN) begin
            r.new_window_state = WS_PARTLY;
          end else if (dir_swapped && ws == WS_SHUT) begin
            r.new_window_state = WS_PARTLY;
            r.battery_flag_clear = 1'b1;
          end
        end
        // zero reference means nothing sampled yet; sampling a zero keeps it empty
        if (fault) begin
          if (fault_ref == '0) begin
            fault_ref = step_cnt;
          end else begin
            dist_full = longint'($signed(step_cnt)) - longint'($signed(fault_ref));
            if (dist_full < 0) dist_full = -dist_full;
            dist_lo = dist_full[DIST_WIDTH-1:0];
            if (dist_lo > DIST_LIMIT) begin
              fault_ref = '0;
              r.fault_recovered = 1'b1;
            end
          end
        end
      end
      // deadline renews on every low edge, accepted or not
      deadline = ts + TIME_WIDTH'(filter_ms);
    end
    r.position = step_cnt;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Sample both channels and the register port
  always @(posedge clk) begin
    step_result_t want;
    if (!rst_n) begin
      dir_swapped = 1'b0;
      filter_ms   = FILTER_TIME_RESET;
      deadline    = '0;
      step_cnt    = '0;
      fault_ref   = '0;
      expected_steps.delete();
      mismatches  = 0;
      in_flight   = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index_t'(cfg_index))
          CFG_DIR_MAP:     dir_swapped = cfg_wdata[0];
          CFG_FILTER_TIME: filter_ms = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        expected_steps.push_back(track_edge(in_timestamp, in_hall_level, in_direction_level,
                                            win_state_t'(in_window_state), in_fault_active));
      end
      if (out_valid && out_ready) begin
        if (expected_steps.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = expected_steps.pop_front();
          if (out_accepted !== want.accepted)
            report_mismatch($sformatf("accepted got %0b exp %0b", out_accepted, want.accepted));
          if (out_moving_closed !== want.moving_closed)
            report_mismatch($sformatf("moving_closed got %0b exp %0b", out_moving_closed,
                                      want.moving_closed));
          if (out_position !== want.position)
            report_mismatch($sformatf("position got %0d exp %0d", out_position, want.position));
          if (out_new_window_state !== want.new_window_state)
            report_mismatch($sformatf("new_window_state got %0d exp %0d", out_new_window_state,
                                      want.new_window_state));
          if (out_battery_flag_clear !== want.battery_flag_clear)
            report_mismatch($sformatf("battery_flag_clear got %0b exp %0b",
                                      out_battery_flag_clear, want.battery_flag_clear));
          if (out_fault_recovered !== want.fault_recovered)
            report_mismatch($sformatf("fault_recovered got %0b exp %0b", out_fault_recovered,
                                      want.fault_recovered));
        end
      end
      in_flight = expected_steps.size();
    end
  end

endmodule

FILE: test/tb.sv
module tb;
  import hspt_pkg::*;

  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned HOLD_CYCLES      = 300;
  localparam int unsigned EDGES_PER_PHASE  = 245;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_we;
  logic [0:0]                   cfg_index;
  logic [FILTER_TIME_WIDTH-1:0] cfg_wdata;
  logic                         in_valid;
  logic                         in_ready;
  logic [31:0]                  in_timestamp;
  logic                         in_hall_level;
  logic                         in_direction_level;
  logic [1:0]                   in_window_state;
  logic                         in_fault_active;
  logic                         out_valid;
  logic                         out_ready;
  logic                         out_accepted;
  logic                         out_moving_closed;
  logic signed [15:0]           out_position;
  logic [1:0]                   out_new_window_state;
  logic                         out_battery_flag_clear;
  logic                         out_fault_recovered;
  int                           mismatches;
  int                           in_flight;

  int unsigned cycle_cnt = 0;
  logic        quiet;      // both sides run without gaps while set
  logic        hold_req;   // asks the receiver for one long hold-off
  logic [31:0] now_ms;
  int unsigned filter_ms;
  logic        dir_now;
  logic        fault_now;
  int          dir_left;
  int          fault_left;

  hall_step_position_tracker i_dut (.*);

  hspt_step_checker i_checker (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offer one edge after a random gap; returns at the falling edge after acceptance
  task automatic offer_edge(input logic [31:0] ts, input logic hall, input logic closing,
                            input logic [1:0] ws, input logic fault);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_timestamp       <= ts;
    in_hall_level      <= hall;
    in_direction_level <= closing;
    in_window_state    <= ws;
    in_fault_active    <= fault;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop sending and wait until every result is back
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (in_flight != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apply_setting(input logic dir_map, input int unsigned filt);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DIR_MAP;
    cfg_wdata <= FILTER_TIME_WIDTH'(dir_map);
    @(negedge clk);
    cfg_index <= CFG_FILTER_TIME;
    cfg_wdata <= FILTER_TIME_WIDTH'(filt);
    @(negedge clk);
    cfg_we    <= 1'b0;
    filter_ms = filt;
    @(negedge clk);
  endtask

  // Mostly edges spaced past the filter, with runs of one direction and of fault
  task automatic random_edge();
    int          pick;
    logic [31:0] ts;
    logic        hall;
    pick = $urandom_range(0, 99);
    hall = 1'b0;
    if (dir_left == 0) begin
      dir_now  = 1'($urandom_range(0, 1));
      dir_left = $urandom_range(1, 20);
    end
    if (fault_left == 0) begin
      fault_now  = ($urandom_range(0, 2) == 0);
      fault_left = $urandom_range(1, 15);
    end
    dir_left--;
    fault_left--;
    if (pick < 5) begin
      hall = 1'b1;
      ts   = $urandom;
    end else if (pick < 9) begin
      now_ms = $urandom;
      ts     = now_ms;
    end else if (pick < 10) begin
      // close to the top of the time range, so the deadline wraps
      now_ms = 32'hFFFF_FFFF - $urandom_range(0, filter_ms + 2);
      ts     = now_ms;
    end else if (pick < 25) begin
      now_ms = now_ms + $urandom_range(0, filter_ms);
      ts     = now_ms;
    end else begin
      now_ms = now_ms + filter_ms + 1 + $urandom_range(0, 300);
      ts     = now_ms;
    end
    if ($urandom_range(0, 59) == 0) quiet = !quiet;
    offer_edge(ts, hall, dir_now, 2'($urandom_range(0, 3)), fault_now);
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 11);
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Stimulus
  initial begin
    int phase;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_DIR_MAP;
    cfg_wdata          = '0;
    in_valid           = 1'b0;
    in_timestamp       = '0;
    in_hall_level      = 1'b0;
    in_direction_level = 1'b0;
    in_window_state    = WS_SHUT;
    in_fault_active    = 1'b0;
    quiet              = 1'b0;
    hold_req           = 1'b0;
    now_ms             = '0;
    filter_ms          = FILTER_TIME_RESET;
    dir_now            = 1'b0;
    fault_now          = 1'b0;
    dir_left           = 0;
    fault_left         = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed edges at the reset settings
    offer_edge(32'd0, 1'b0, 1'b0, WS_SHUT, 1'b0);    // equal to deadline: rejected
    offer_edge(32'd5, 1'b1, 1'b1, WS_OPEN, 1'b1);    // hall high: ignored
    offer_edge(32'd3, 1'b0, 1'b0, WS_SHUT, 1'b0);    // manual open from shut
    offer_edge(32'd4, 1'b0, 1'b1, WS_OPEN, 1'b0);    // inside filter window
    offer_edge(32'd10, 1'b0, 1'b1, WS_OPEN, 1'b0);   // manual close from open
    offer_edge(32'd20, 1'b0, 1'b0, WS_OTHER, 1'b1);  // fault: reference sampled
    offer_edge(32'd30, 1'b0, 1'b0, WS_PARTLY, 1'b1); // one step away, no recovery
    offer_edge(32'd40, 1'b0, 1'b0, WS_PARTLY, 1'b1); // two steps: recovered
    offer_edge(32'd50, 1'b0, 1'b1, WS_PARTLY, 1'b1);
    offer_edge(32'd60, 1'b0, 1'b1, WS_OTHER, 1'b1);
    offer_edge(32'd70, 1'b0, 1'b1, WS_PARTLY, 1'b1);
    offer_edge(32'd80, 1'b0, 1'b1, WS_PARTLY, 1'b1); // negative reference
    offer_edge(32'd90, 1'b0, 1'b1, WS_SHUT, 1'b1);
    offer_edge(32'd100, 1'b0, 1'b1, WS_PARTLY, 1'b1);
    offer_edge(32'd110, 1'b0, 1'b0, WS_OPEN, 1'b0);
    offer_edge(32'd120, 1'b0, 1'b0, WS_OPEN, 1'b0);
    offer_edge(32'd130, 1'b0, 1'b0, WS_OTHER, 1'b1); // position zero leaves reference empty
    offer_edge(32'd140, 1'b0, 1'b0, WS_OTHER, 1'b1);
    offer_edge(32'hFFFF_FFFE, 1'b0, 1'b0, WS_SHUT, 1'b0); // deadline wraps to zero
    offer_edge(32'hFFFF_FFFF, 1'b0, 1'b1, WS_OPEN, 1'b0);
    offer_edge(32'd0, 1'b0, 1'b1, WS_OPEN, 1'b0);
    offer_edge(32'hFFFF_FFFF, 1'b1, 1'b1, WS_OTHER, 1'b1);

    // Random phases over several register settings
    for (phase = 0; phase < 4; phase++) begin
      if (phase != 0) settle();
      case (phase)
        1: apply_setting(1'b1, 0);
        2: apply_setting(1'b0, 65535);
        3: apply_setting(1'b1, $urandom_range(1, 40));
        default: ;
      endcase
      if (phase == 1) hold_req = 1'b1;
      repeat (EDGES_PER_PHASE) random_edge();
    end

    settle();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && in_flight == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
